### design/sntd_pkg.sv
// Shared types and constants for the three-digit signed display formatter.
// No dependencies; used by every module of the block.
`default_nettype none

package sntd_pkg;

  // working width of the number before the display range check
  localparam int NUM_W = 24;

  // display symbol codes
  localparam logic [3:0] SYM_BLANK = 4'd10;
  localparam logic [3:0] SYM_MINUS = 4'd11;
  localparam logic [3:0] SYM_E     = 4'd12;
  localparam logic [3:0] SYM_R     = 4'd13;

  // showable range, and a value outside it that forces the error display
  localparam logic signed [NUM_W-1:0] NUM_MIN = -24'sd99;
  localparam logic signed [NUM_W-1:0] NUM_MAX = 24'sd999;
  localparam logic signed [NUM_W-1:0] NUM_OOR = 24'sd1000;

  // decimal exponent codes
  localparam logic signed [2:0] EXP_M2 = -3'sd2;
  localparam logic signed [2:0] EXP_M1 = -3'sd1;
  localparam logic signed [2:0] EXP_P1 = 3'sd1;
  localparam logic signed [2:0] EXP_P2 = 3'sd2;

  // command codes
  localparam logic CMD_FIXED = 1'b0;
  localparam logic CMD_TEMP  = 1'b1;

  typedef enum logic [2:0] {
    SCALE_CELSIUS    = 3'd0,
    SCALE_KELVIN     = 3'd1,
    SCALE_FAHRENHEIT = 3'd2,
    SCALE_RANKINE    = 3'd3,
    SCALE_DELISLE    = 3'd4,
    SCALE_REAUMUR    = 3'd5,
    SCALE_NEWTON     = 3'd6,
    SCALE_ROMER      = 3'd7
  } scale_t;

  // converted number and the dot requests that travel with it
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic             ldot;
    logic             mdot;
  } sntd_num_t;

endpackage

`default_nettype wire

### design/sntd_convert.sv
// Number stage: scales a fixed-point value or converts a Celsius reading.
// Depends on sntd_pkg; purely combinational, registered by the top level.
`default_nettype none

module sntd_convert
  import sntd_pkg::*;
(
  input  wire logic               cmd,
  input  wire logic signed [15:0] value,
  input  wire logic signed [2:0]  exponent,
  input  wire logic [2:0]         scale,
  output sntd_num_t               res
);

  localparam logic signed [NUM_W-1:0] K21  = 24'sd21;
  localparam logic signed [NUM_W-1:0] K300 = 24'sd300;
  localparam logic signed [NUM_W-1:0] K100 = 24'sd100;
  localparam logic signed [NUM_W-1:0] K10  = 24'sd10;

  logic signed [NUM_W-1:0] c;
  logic signed [NUM_W-1:0] d;
  logic signed [NUM_W-1:0] fsum;
  logic signed [NUM_W-1:0] temp_num;
  logic signed [NUM_W-1:0] fixed_num;
  logic signed [NUM_W-1:0] romer_num;
  logic signed [NUM_W-1:0] romer_q_s;
  logic [NUM_W-1:0]        romer_abs;
  logic [12:0]             romer_x;
  logic [27:0]             romer_prod;
  logic [9:0]              romer_q;
  logic                    romer_oor;
  logic                    exp_ok;

  assign c    = {{(NUM_W-16){value[15]}}, value};
  assign fsum = c + (c >>> 1) + (c >>> 2) + (c >>> 5);
  assign d    = K100 - c;

  // romer: (21c+300)/40 toward zero; /40 is >>3 then x*13108>>16, exact below 5000
  assign romer_num  = K21 * c + K300;
  assign romer_abs  = romer_num[NUM_W-1] ? NUM_W'(-romer_num) : NUM_W'(romer_num);
  assign romer_oor  = romer_num[NUM_W-1] ? (romer_abs >= NUM_W'(4000))
                                         : (romer_abs >= NUM_W'(40000));
  assign romer_x    = romer_abs[15:3];
  assign romer_prod = {15'b0, romer_x} * 28'd13108;
  assign romer_q    = romer_prod[25:16];
  assign romer_q_s  = romer_num[NUM_W-1] ? -$signed({{(NUM_W-10){1'b0}}, romer_q})
                                         : $signed({{(NUM_W-10){1'b0}}, romer_q});

  always_comb begin
    case (scale_t'(scale))
      SCALE_CELSIUS:    temp_num = c;
      SCALE_KELVIN:     temp_num = c + 24'sd273;
      SCALE_FAHRENHEIT: temp_num = fsum + 24'sd32;
      SCALE_RANKINE:    temp_num = fsum + 24'sd491;
      SCALE_DELISLE:    temp_num = d + (d >>> 1);
      SCALE_REAUMUR:    temp_num = (c >>> 1) + (c >>> 2) + (c >>> 5) + (c >>> 6);
      SCALE_NEWTON:     temp_num = (c >>> 2) + (c >>> 4) + (c >>> 6) + (c >>> 7)
                                   - (c >>> 8) - (c >>> 9);
      SCALE_ROMER:      temp_num = romer_oor ? NUM_OOR : romer_q_s;
      default:          temp_num = c;
    endcase
  end

  assign exp_ok = (exponent >= EXP_M2) && (exponent <= EXP_P2);

  always_comb begin
    if (!exp_ok) begin
      fixed_num = NUM_OOR;
    end else if (exponent == EXP_P2) begin
      fixed_num = c * K100;
    end else if (exponent == EXP_P1) begin
      fixed_num = c * K10;
    end else begin
      fixed_num = c;
    end
  end

  always_comb begin
    res.num  = (cmd == CMD_TEMP) ? temp_num : fixed_num;
    res.ldot = (cmd == CMD_FIXED) && (exponent == EXP_M2);
    res.mdot = (cmd == CMD_FIXED) && (exponent == EXP_M1);
  end

endmodule

`default_nettype wire

### design/sntd_format.sv
// Display stage: range check, three-digit decimal split, blanking and dots.
// Depends on sntd_pkg; purely combinational, registered by the top level.
`default_nettype none

module sntd_format
  import sntd_pkg::*;
(
  input  wire sntd_num_t   num_in,
  output logic [3:0]       left_symbol,
  output logic [3:0]       middle_symbol,
  output logic [3:0]       right_symbol,
  output logic             left_dot,
  output logic             middle_dot,
  output logic             range_error
);

  logic signed [NUM_W-1:0] n;
  logic [NUM_W-1:0]        n_abs;
  logic [9:0]              mag;
  logic [15:0]             h_prod;
  logic [3:0]              hund;
  logic [6:0]              rem;
  logic [14:0]             t_prod;
  logic [3:0]              tens;
  logic [3:0]              ones;
  logic                    neg;
  logic                    err;
  logic [3:0]              s2;
  logic [3:0]              s1;

  assign n     = $signed(num_in.num);
  assign neg   = n[NUM_W-1];
  assign err   = (n < NUM_MIN) || (n > NUM_MAX);
  assign n_abs = neg ? NUM_W'(-n) : NUM_W'(n);
  assign mag   = n_abs[9:0];

  // m/100 as m*41>>12 and r/10 as r*205>>11, exact over the display range
  assign h_prod = {6'b0, mag} * 16'd41;
  assign hund   = h_prod[15:12];
  assign rem    = 7'(mag - 10'(hund) * 10'd100);
  assign t_prod = {8'b0, rem} * 15'd205;
  assign tens   = t_prod[14:11];
  assign ones   = 4'(rem - 7'(tens) * 7'd10);

  always_comb begin
    s2 = (hund == 4'd0) ? SYM_BLANK : hund;
    s1 = (hund == 4'd0 && tens == 4'd0) ? SYM_BLANK : tens;
    if (neg) begin
      s2 = SYM_MINUS;
    end
    // a lit point forces zeros into blank digits up to it
    if (num_in.mdot || num_in.ldot) begin
      if (s1 == SYM_BLANK) begin
        s1 = 4'd0;
      end
    end
    if (num_in.ldot && s2 == SYM_BLANK) begin
      s2 = 4'd0;
    end

    if (err) begin
      left_symbol   = SYM_E;
      middle_symbol = SYM_R;
      right_symbol  = SYM_R;
      left_dot      = 1'b0;
      middle_dot    = 1'b0;
    end else begin
      left_symbol   = s2;
      middle_symbol = s1;
      right_symbol  = ones;
      left_dot      = num_in.ldot;
      middle_dot    = num_in.mdot;
    end
    range_error = err;
  end

endmodule

`default_nettype wire

### design/signed_number_to_three_digit_display_unit.sv
// Top level of the three-digit signed display formatter.
// Depends on sntd_pkg, sntd_convert and sntd_format.
//
// One item is taken in every clock cycle (busy never rises) and its result
// appears on the out_ ports, marked by out_valid, once it has passed an input
// register, a register after the number stage (scaling, temperature
// conversion, divide by 40 by reciprocal multiply) and the result register
// after the decimal split and symbol stage. Results are shown for one cycle
// only and the receiver cannot stall them. The scale register is written with
// cfg_we and used by items accepted after the write.
`default_nettype none

module signed_number_to_three_digit_display_unit
  import sntd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_cmd,
  input  wire logic signed [15:0] in_value,
  input  wire logic signed [2:0]  in_exponent,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_wdata,
  output logic                    out_valid,
  output logic [3:0]              out_left_symbol,
  output logic [3:0]              out_middle_symbol,
  output logic [3:0]              out_right_symbol,
  output logic                    out_left_dot,
  output logic                    out_middle_dot,
  output logic                    out_range_error
);

  logic               temp_scale_r;
  logic [2:0]         scale_r;
  logic               s1_valid_r;
  logic               s1_cmd_r;
  logic signed [15:0] s1_value_r;
  logic signed [2:0]  s1_exponent_r;
  logic               s2_valid_r;
  sntd_num_t          s2_num_r;
  sntd_num_t          s2_num_nxt;
  logic [3:0]         left_nxt;
  logic [3:0]         middle_nxt;
  logic [3:0]         right_nxt;
  logic               ldot_nxt;
  logic               mdot_nxt;
  logic               err_nxt;

  assign busy = 1'b0;

  // holds the scale register and marks that it has been written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r      <= 3'd0;
      temp_scale_r <= 1'b0;
    end else if (cfg_we) begin
      scale_r      <= cfg_wdata;
      temp_scale_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
      s2_valid_r <= s1_valid_r;
      out_valid  <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_cmd_r      <= in_cmd;
      s1_value_r    <= in_value;
      s1_exponent_r <= in_exponent;
    end
    if (s1_valid_r) begin
      s2_num_r <= s2_num_nxt;
    end
    if (s2_valid_r) begin
      out_left_symbol   <= left_nxt;
      out_middle_symbol <= middle_nxt;
      out_right_symbol  <= right_nxt;
      out_left_dot      <= ldot_nxt;
      out_middle_dot    <= mdot_nxt;
      out_range_error   <= err_nxt;
    end
  end

  sntd_convert u_convert (
    .cmd      (s1_cmd_r),
    .value    (s1_value_r),
    .exponent (s1_exponent_r),
    .scale    (temp_scale_r ? scale_r : 3'd0),
    .res      (s2_num_nxt)
  );

  sntd_format u_format (
    .num_in        (s2_num_r),
    .left_symbol   (left_nxt),
    .middle_symbol (middle_nxt),
    .right_symbol  (right_nxt),
    .left_dot      (ldot_nxt),
    .middle_dot    (mdot_nxt),
    .range_error   (err_nxt)
  );

endmodule

`default_nettype wire

### design/sntd_checker.sv
// Port-level checks for the three-digit signed display formatter.
// Depends on sntd_pkg; bound to signed_number_to_three_digit_display_unit.
`default_nettype none

module sntd_checker
  import sntd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic [3:0]         out_left_symbol,
  input wire logic [3:0]         out_middle_symbol,
  input wire logic [3:0]         out_right_symbol,
  input wire logic               out_left_dot,
  input wire logic               out_middle_dot,
  input wire logic               out_range_error
);

  // every word out has an accepted input behind it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result word without accepted input");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |->
      out_left_symbol == SYM_E && out_middle_symbol == SYM_R &&
      out_right_symbol == SYM_R && !out_left_dot && !out_middle_dot)
    else $error("error display malformed");

  a_one_dot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_left_dot && out_middle_dot))
    else $error("two points lit");

  a_dot_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_left_dot |->
      out_middle_symbol <= 4'd9 &&
      (out_left_symbol <= 4'd9 || out_left_symbol == SYM_MINUS))
    else $error("blank digit under lit point");

  a_right_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error |-> out_right_symbol <= 4'd9)
    else $error("right digit not a digit");

endmodule

bind signed_number_to_three_digit_display_unit sntd_checker u_sntd_checker (.*);

`default_nettype wire
